FILE: rtl/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg: shared types and constants for the timer table
// Holds the item structs, the operation codes and the control/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mtt_pkg;

    // Default table depth and the number of slots a 4-bit slot field reaches.
    localparam int NUM_TIMERS_DEF = 16;
    localparam int SLOT_REACH     = 16;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_TICK = 2'd2,
        OP_RSVD = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [3:0]  timer_slot;
        logic [31:0] start_time;
        logic [31:0] reload_time;
        logic        is_periodic;
        logic [15:0] elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic [3:0] fired_slot;
        logic       fired_periodic;
        logic       last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // input transfer: apply add/delete, capture tick data
        logic prime;    // read the first slot of the scan
        logic step;     // retire the current slot and read the next
        logic flush;    // hand the held result on as the final one
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic run_enable;
        logic last_slot;
        logic stall;
        logic pend_valid;
        logic out_free;
    } t_ctl_status;

endpackage

FILE: rtl/mtt_ctrl.sv
// ----------------------------------------------------------------------------
// mtt_ctrl: sequencing controller for the timer table
// Accepts items, starts a scan of the slots on an honored tick and closes
// the scan by passing on the held final result, if there is one.
// ----------------------------------------------------------------------------
module mtt_ctrl
    import mtt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_op         i_op,
    input  t_ctl_status i_status,
    output logic        o_in_ready,
    output t_ctl_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PRIME = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_op == OP_TICK && i_status.run_enable) begin
                        n_state = S_PRIME;
                    end
                end
            end
            S_PRIME: begin
                o_cmd.prime = 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                if (!i_status.stall) begin
                    o_cmd.step = 1'b1;
                    if (i_status.last_slot) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/mtt_datapath.sv
// ----------------------------------------------------------------------------
// mtt_datapath: timer storage, aging arithmetic and result registers
// Keeps the per-slot times in memories, the valid marks in flops, and
// holds one found result back so the final one of a tick can be flagged.
// ----------------------------------------------------------------------------
module mtt_datapath
    import mtt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_in,
    input  t_ctl_cmd    i_cmd,
    output t_ctl_status o_status,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out
);

    localparam int AW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SPAN = (NUM_TIMERS < SLOT_REACH) ? NUM_TIMERS : SLOT_REACH;
    localparam int IW   = (SPAN > 1) ? $clog2(SPAN) : 1;
    localparam logic [6:0]    NT_LIMIT  = 7'(NUM_TIMERS);
    localparam logic [IW-1:0] IDX_FINAL = IW'(SPAN - 1);

    logic [31:0] r_rem_mem [NUM_TIMERS];
    logic [31:0] r_rel_mem [NUM_TIMERS];
    logic        r_per_mem [NUM_TIMERS];

    logic [NUM_TIMERS-1:0] r_valid;
    logic                  r_run_en;
    logic [15:0]           r_elapsed;
    logic [IW-1:0]         r_idx;
    logic [31:0]           r_rd_rem;
    logic [31:0]           r_rd_rel;
    logic                  r_rd_per;
    logic                  r_pend_valid;
    logic [3:0]            r_pend_slot;
    logic                  r_pend_per;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic          slot_in_range;
    logic          is_add;
    logic          is_del;
    logic [AW-1:0] slot_addr;
    logic [AW-1:0] idx_addr;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_rem;
    logic [31:0]   elapsed_ext;
    logic [31:0]   aged;
    logic          cur_valid;
    logic          fire;
    logic          out_free;
    logic          push_mid;
    logic          push_final;

    assign slot_in_range = {3'b000, i_in.timer_slot} < NT_LIMIT;
    assign is_add        = i_cmd.accept && i_in.op == OP_ADD && slot_in_range;
    assign is_del        = i_cmd.accept && i_in.op == OP_DEL && slot_in_range;
    assign slot_addr     = AW'(i_in.timer_slot);
    assign idx_addr      = AW'(r_idx);

    // Aging of the slot whose data sits in the read registers.
    assign elapsed_ext = {16'd0, r_elapsed};
    assign aged        = (r_rd_rem < elapsed_ext) ? 32'd0 : r_rd_rem - elapsed_ext;
    assign cur_valid   = r_valid[idx_addr];
    assign fire        = cur_valid && aged == 32'd0;

    assign out_free   = !r_out_valid || i_out_ready;
    assign push_mid   = i_cmd.step && fire && r_pend_valid;
    assign push_final = i_cmd.flush;

    // The next slot is read while the current one is retired.
    assign rd_en   = i_cmd.prime || (i_cmd.step && r_idx != IDX_FINAL);
    assign rd_addr = i_cmd.step ? AW'(r_idx + IW'(1)) : idx_addr;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_addr;
        wr_rem  = aged;
        if (is_add) begin
            wr_en   = 1'b1;
            wr_addr = slot_addr;
            wr_rem  = i_in.start_time;
        end else if (i_cmd.step && cur_valid) begin
            // A one-shot that fires is freed, so its time needs no update.
            wr_en  = !fire || r_rd_per;
            wr_rem = fire ? r_rd_rel : aged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_rem_mem[wr_addr] <= wr_rem;
        end
        if (rd_en) begin
            r_rd_rem <= r_rem_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_add) begin
            r_rel_mem[slot_addr] <= i_in.reload_time;
            r_per_mem[slot_addr] <= i_in.is_periodic;
        end
        if (rd_en) begin
            r_rd_rel <= r_rel_mem[rd_addr];
            r_rd_per <= r_per_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_run_en <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_run_en <= i_cfg_wdata;
            end
            if (is_add) begin
                r_valid[slot_addr] <= 1'b1;
            end else if (is_del) begin
                r_valid[slot_addr] <= 1'b0;
            end else if (i_cmd.step && fire && !r_rd_per) begin
                r_valid[idx_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_elapsed <= i_in.elapsed_ms;
            r_idx     <= '0;
        end else if (i_cmd.step && r_idx != IDX_FINAL) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.step && fire) begin
            r_pend_valid <= 1'b1;
        end else if (push_final) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && fire) begin
            r_pend_slot <= 4'(r_idx);
            r_pend_per  <= r_rd_per;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push_mid || push_final) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_mid || push_final) begin
            r_out.fired_slot     <= r_pend_slot;
            r_out.fired_periodic <= r_pend_per;
            r_out.last           <= push_final;
        end
    end

    assign o_status.run_enable = r_run_en;
    assign o_status.last_slot  = r_idx == IDX_FINAL;
    assign o_status.stall      = fire && r_pend_valid && !out_free;
    assign o_status.pend_valid = r_pend_valid;
    assign o_status.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: rtl/multi_timer_table.sv
// ----------------------------------------------------------------------------
// multi_timer_table: slot-indexed table of one-shot and periodic timers
// Input items add a timer, delete a timer, or tick the table forward.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid / o_in_ready / i_in) carries add, delete
//   and tick items. Add and delete produce no output. A tick with
//   run_enable set scans slots 0 to min(NUM_TIMERS,16)-1 in order, one
//   slot per cycle while the receiver does not stall, through the timer
//   memories; an item passes through accept, first read, the slot scan
//   and final hand-off before the next is taken. The scan is the limit on rate.
//   Each expired timer produces one output transfer on o_out_valid /
//   i_out_ready / o_out in ascending slot order; the last one of the tick
//   carries last = 1. A result is held until the next expiring slot or the
//   end of the scan, then presented; a tick while run_enable is 0 is dropped.
//   If the receiver stalls, the scan holds at the next expiring slot until
//   the output register frees up. The user must write run_enable through
//   i_cfg_we / i_cfg_wdata while the block is idle; the block does not enforce it.
//   Synchronous reset frees all timers and clears run_enable.
// ----------------------------------------------------------------------------
module multi_timer_table
    import mtt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);

    t_ctl_cmd    ctl_cmd;
    t_ctl_status ctl_status;

    mtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in.op),
        .i_status   (ctl_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (ctl_cmd)
    );

    mtt_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (ctl_cmd),
        .o_status    (ctl_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
